### rtl/qda_pkg.sv
// ----------------------------------------------------------------------------
// qda_pkg
// Shared types and constants of the quadrature detent accelerator.
// ----------------------------------------------------------------------------
package qda_pkg;

    localparam int LINE_W     = 2;
    localparam int TIME_W     = 32;
    localparam int POS_W      = 32;
    localparam int STEP_W     = 6;
    localparam int TIMEOUT_W  = 16;
    localparam int THRESH_W   = 8;
    localparam int MULT_W     = 5;
    localparam int FAST_W     = 8;
    localparam int OFFSET_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [MULT_W-1:0]    STEP_LIMIT       = 5'd16;
    localparam logic signed [OFFSET_W-1:0] EDGES_PER_DETENT = 4'sd4;
    localparam logic [FAST_W-1:0]    FAST_MAX         = 8'd255;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET    = 16'd100;
    localparam logic [THRESH_W-1:0]  THRESHOLD_RESET  = 8'd3;
    localparam logic [MULT_W-1:0]    MULTIPLIER_RESET = 5'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEL_TIMEOUT    = 2'd0,
        REG_ACCEL_THRESHOLD  = 2'd1,
        REG_ACCEL_MULTIPLIER = 2'd2
    } cfg_reg_t;

    // Edge step for each {previous lines, current lines} code.
    localparam logic signed [1:0] QUAD_TABLE [16] = '{
         2'sd0, -2'sd1,  2'sd1,  2'sd0,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd0,  2'sd1, -2'sd1,  2'sd0
    };

    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout_ms;
        logic [THRESH_W-1:0]  threshold;
        logic [MULT_W-1:0]    multiplier;
    } cfg_t;

    typedef struct packed {
        logic signed [STEP_W-1:0] step_value;
        logic                     step_valid;
        logic                     accelerating;
        logic signed [POS_W-1:0]  position;
    } result_t;

endpackage

### rtl/qda_ifs.sv
// ----------------------------------------------------------------------------
// qda_ifs
// Valid/ready channels of the quadrature detent accelerator.
// ----------------------------------------------------------------------------
interface qda_sample_if;
    import qda_pkg::*;

    logic              valid;
    logic              ready;
    logic              line_a;
    logic              line_b;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, line_a, line_b, now_ms, input ready);
    modport sink (input valid, line_a, line_b, now_ms, output ready);
endinterface

interface qda_result_if;
    import qda_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [STEP_W-1:0] step_value;
    logic                     step_valid;
    logic                     accelerating;
    logic signed [POS_W-1:0]  position;

    modport source (output valid, step_value, step_valid, accelerating, position,
                    input ready);
    modport sink (input valid, step_value, step_valid, accelerating, position,
                  output ready);
endinterface

interface qda_cfg_if;
    import qda_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/quadrature_detent_accelerator_top.sv
// ----------------------------------------------------------------------------
// quadrature_detent_accelerator_top
// Quadrature encoder decoder with detent stepping and step acceleration.
//
// Each sample word (A and B levels plus a millisecond timestamp) yields one
// result word: the running edge count, a detent step of +-1 (scaled by the
// multiplier and clamped to +-16 while accelerating), a step flag and the
// acceleration flag. A sample is held in an input register, decoded in a
// single pass against the decoder state and stored in the result register,
// so the block takes one sample per clock; only a stalled result register
// holds back new samples. The first sample after reset only loads the line
// state.
// ----------------------------------------------------------------------------
module quadrature_detent_accelerator_top (
    input  logic        clk,
    input  logic        rst_n,
    qda_sample_if.sink  sample,
    qda_result_if.source result,
    qda_cfg_if.sink     cfg
);
    import qda_pkg::*;

    logic              s1_valid_reg, s1_valid_next;
    logic              s1_line_a_reg;
    logic              s1_line_b_reg;
    logic [TIME_W-1:0] s1_now_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;

    logic              can_move;
    logic              accept;
    logic              commit;
    cfg_t              settings;
    result_t           core_result;

    qda_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .settings (settings)
    );

    qda_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .commit   (commit),
        .line_a   (s1_line_a_reg),
        .line_b   (s1_line_b_reg),
        .now_ms   (s1_now_reg),
        .settings (settings),
        .result   (core_result)
    );

    assign can_move     = !out_valid_reg || result.ready;
    assign sample.ready = !s1_valid_reg || can_move;
    assign accept       = sample.valid && sample.ready;
    assign commit       = s1_valid_reg && can_move;

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (can_move)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
        out_valid_next = can_move ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_line_a_reg <= sample.line_a;
            s1_line_b_reg <= sample.line_b;
            s1_now_reg    <= sample.now_ms;
        end
        if (commit)
        begin
            out_reg <= core_result;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.step_value   = out_reg.step_value;
    assign result.step_valid   = out_reg.step_valid;
    assign result.accelerating = out_reg.accelerating;
    assign result.position     = out_reg.position;

    // A sample word taken in is always waiting in the input register next cycle.
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted sample word not held in input register");

    // Hold the input word while the result register is stalled.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !can_move) |=> (s1_valid_reg && $stable(s1_now_reg)))
        else $error("input word lost during output stall");

    // No detent means a zero step; an unaccelerated detent is a single step.
    a_step_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            ((out_reg.step_valid || out_reg.step_value == '0) &&
             (!out_reg.step_valid || out_reg.accelerating ||
              out_reg.step_value == 6'sd1 || out_reg.step_value == -6'sd1)))
        else $error("result step value inconsistent with step flags");

endmodule

### rtl/qda_cfg.sv
// ----------------------------------------------------------------------------
// qda_cfg
// Acceleration setting registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module qda_cfg (
    input  logic          clk,
    input  logic          rst_n,
    qda_cfg_if.sink       cfg,
    output qda_pkg::cfg_t settings
);
    import qda_pkg::*;

    cfg_t settings_reg;
    cfg_t settings_next;

    assign cfg.ready = 1'b1;
    assign settings  = settings_reg;

    always_comb
    begin
        settings_next = settings_reg;
        if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_ACCEL_TIMEOUT:    settings_next.timeout_ms = cfg.data;
                REG_ACCEL_THRESHOLD:  settings_next.threshold  = cfg.data[THRESH_W-1:0];
                REG_ACCEL_MULTIPLIER: settings_next.multiplier = cfg.data[MULT_W-1:0];
                default:              settings_next = settings_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settings_reg.timeout_ms <= TIMEOUT_RESET;
            settings_reg.threshold  <= THRESHOLD_RESET;
            settings_reg.multiplier <= MULTIPLIER_RESET;
        end
        else
        begin
            settings_reg <= settings_next;
        end
    end

endmodule

### rtl/qda_core.sv
// ----------------------------------------------------------------------------
// qda_core
// Decoder state and the single-pass decode, detent and acceleration logic.
// ----------------------------------------------------------------------------
module qda_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       commit,
    input  logic                       line_a,
    input  logic                       line_b,
    input  logic [qda_pkg::TIME_W-1:0] now_ms,
    input  qda_pkg::cfg_t              settings,
    output qda_pkg::result_t           result
);
    import qda_pkg::*;

    logic                       primed_reg, primed_next;
    logic [LINE_W-1:0]          prev_lines_reg, prev_lines_next;
    logic [POS_W-1:0]           edge_count_reg, edge_count_next;
    // Edges moved since the last detent; stays within -3..3 between samples.
    logic signed [OFFSET_W-1:0] offset_reg, offset_next;
    logic [TIME_W-1:0]          last_ms_reg, last_ms_next;
    logic [FAST_W-1:0]          fast_reg, fast_next;
    logic                       accel_reg, accel_next;

    logic [LINE_W-1:0]          lines;
    logic signed [1:0]          edge_step;
    logic signed [OFFSET_W-1:0] offset_sum;
    logic                       detent;
    logic [TIME_W-1:0]          elapsed;
    logic                       fast;
    logic [FAST_W-1:0]          fast_inc;
    logic [MULT_W-1:0]          magnitude;
    logic [STEP_W-1:0]          mag_ext;

    assign lines      = {line_a, line_b};
    assign edge_step  = QUAD_TABLE[{prev_lines_reg, lines}];
    assign offset_sum = offset_reg + OFFSET_W'(edge_step);
    assign detent     = primed_reg &&
                        (offset_sum >= EDGES_PER_DETENT || offset_sum <= -EDGES_PER_DETENT);
    assign elapsed    = now_ms - last_ms_reg;
    assign fast       = elapsed < {{(TIME_W-TIMEOUT_W){1'b0}}, settings.timeout_ms};
    assign fast_inc   = (fast_reg == FAST_MAX) ? FAST_MAX : fast_reg + 1'b1;

    always_comb
    begin
        primed_next     = 1'b1;
        prev_lines_next = lines;
        edge_count_next = edge_count_reg;
        offset_next     = offset_reg;
        last_ms_next    = last_ms_reg;
        fast_next       = fast_reg;
        accel_next      = accel_reg;
        if (primed_reg)
        begin
            edge_count_next = edge_count_reg + POS_W'(edge_step);
            offset_next     = offset_sum;
        end
        if (detent)
        begin
            offset_next  = '0;
            last_ms_next = now_ms;
            if (fast)
            begin
                fast_next  = fast_inc;
                accel_next = accel_reg || (fast_inc >= settings.threshold);
            end
            else
            begin
                fast_next  = '0;
                accel_next = 1'b0;
            end
        end
    end

    // An unaccelerated detent is one step; clamp the accelerated step to STEP_LIMIT (16).
    always_comb
    begin
        if (!accel_next)
        begin
            magnitude = MULT_W'(1);
        end
        else if (settings.multiplier > STEP_LIMIT)
        begin
            magnitude = STEP_LIMIT;
        end
        else
        begin
            magnitude = settings.multiplier;
        end
        mag_ext = {1'b0, magnitude};
    end

    always_comb
    begin
        result.step_valid   = detent;
        result.accelerating = accel_next;
        result.position     = edge_count_next;
        if (!detent)
        begin
            result.step_value = '0;
        end
        else if (offset_sum < 0)
        begin
            result.step_value = -$signed(mag_ext);
        end
        else
        begin
            result.step_value = $signed(mag_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg     <= 1'b0;
            prev_lines_reg <= '0;
            edge_count_reg <= '0;
            offset_reg     <= '0;
            last_ms_reg    <= '0;
            fast_reg       <= '0;
            accel_reg      <= 1'b0;
        end
        else if (commit)
        begin
            primed_reg     <= primed_next;
            prev_lines_reg <= prev_lines_next;
            edge_count_reg <= edge_count_next;
            offset_reg     <= offset_next;
            last_ms_reg    <= last_ms_next;
            fast_reg       <= fast_next;
            accel_reg      <= accel_next;
        end
    end

endmodule

### tb/qda_detent_scoreboard.sv
// ----------------------------------------------------------------------------
// qda_detent_scoreboard
// Watches the sample, result and register channels of the quadrature detent
// accelerator. It decodes every accepted sample word into the expected result
// word and compares each accepted result word with the oldest one waiting.
// ----------------------------------------------------------------------------
module qda_detent_scoreboard (
    input  logic  clk,
    input  logic  rst_n,
    qda_sample_if sample,
    qda_result_if result,
    qda_cfg_if    cfg,
    output int    failures,
    output int    outstanding
);
    import qda_pkg::*;

    // Decoder state as the block should hold it
    logic                  seeded       = 1'b0;
    logic [LINE_W-1:0]     last_lines   = '0;
    logic [POS_W-1:0]      edge_total   = '0;
    logic [POS_W-1:0]      detent_mark  = '0;
    logic [TIME_W-1:0]     detent_stamp = '0;
    logic [FAST_W-1:0]     fast_run     = '0;
    logic                  accel_active = 1'b0;

    logic [TIMEOUT_W-1:0]  timeout_cfg    = TIMEOUT_RESET;
    logic [THRESH_W-1:0]   threshold_cfg  = THRESHOLD_RESET;
    logic [MULT_W-1:0]     multiplier_cfg = MULTIPLIER_RESET;

    result_t               expected_words[$];

    initial
    begin
        failures    = 0;
        outstanding = 0;
    end

    // Position of a line pair along the forward sequence 00, 10, 11, 01
    function automatic logic [1:0] gray_slot(logic [LINE_W-1:0] lines);
        return {lines[0], lines[1] ^ lines[0]};
    endfunction

    function automatic int edge_move(logic [LINE_W-1:0] from, logic [LINE_W-1:0] to);
        logic [1:0] diff;
        diff = gray_slot(to) - gray_slot(from);
        if (diff == 2'd1)
            return 1;
        else if (diff == 2'd3)
            return -1;
        return 0;
    endfunction

    function automatic result_t decode_sample(logic a, logic b, logic [TIME_W-1:0] now);
        logic [LINE_W-1:0]       lines;
        logic signed [POS_W-1:0] delta;
        logic [TIME_W-1:0]       elapsed;
        int                      raw;
        int                      step;
        result_t                 word;
        lines = {a, b};
        step = 0;
        word.step_valid = 1'b0;
        if (!seeded)
        begin
            last_lines = lines;
            seeded = 1'b1;
        end
        else
        begin
            if (lines != last_lines)
            begin
                edge_total = edge_total + POS_W'(edge_move(last_lines, lines));
                last_lines = lines;
            end
            delta = edge_total - detent_mark;
            if (delta >= 4 || delta <= -4)
            begin
                raw = delta / 4;
                elapsed = now - detent_stamp;
                detent_mark = edge_total;
                detent_stamp = now;
                if (elapsed < TIME_W'(timeout_cfg))
                begin
                    if (fast_run != FAST_MAX)
                        fast_run = fast_run + 1'b1;
                    if (fast_run >= threshold_cfg)
                        accel_active = 1'b1;
                end
                else
                begin
                    fast_run = '0;
                    accel_active = 1'b0;
                end
                step = accel_active ? raw * int'(multiplier_cfg) : raw;
                if (step > 16)
                    step = 16;
                if (step < -16)
                    step = -16;
                word.step_valid = 1'b1;
            end
        end
        word.step_value   = STEP_W'(step);
        word.accelerating = accel_active;
        word.position     = edge_total;
        return word;
    endfunction

    task automatic check_field(string name, logic signed [POS_W-1:0] want,
                               logic signed [POS_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            seeded         = 1'b0;
            last_lines     = '0;
            edge_total     = '0;
            detent_mark    = '0;
            detent_stamp   = '0;
            fast_run       = '0;
            accel_active   = 1'b0;
            timeout_cfg    = TIMEOUT_RESET;
            threshold_cfg  = THRESHOLD_RESET;
            multiplier_cfg = MULTIPLIER_RESET;
            expected_words.delete();
            outstanding    = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_ACCEL_TIMEOUT:    timeout_cfg    = cfg.data;
                    REG_ACCEL_THRESHOLD:  threshold_cfg  = cfg.data[THRESH_W-1:0];
                    REG_ACCEL_MULTIPLIER: multiplier_cfg = cfg.data[MULT_W-1:0];
                    default: ;
                endcase
            end
            if (sample.valid && sample.ready)
                expected_words.push_back(decode_sample(sample.line_a, sample.line_b,
                                                       sample.now_ms));
            if (result.valid && result.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected result word, step %0d, position %0d",
                             $time, result.step_value, result.position);
                    failures++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("step_value", want.step_value, result.step_value);
                    check_field("step_valid", want.step_valid, result.step_valid);
                    check_field("accelerating", want.accelerating, result.accelerating);
                    check_field("position", want.position, result.position);
                end
            end
            outstanding = expected_words.size();
        end
    end

endmodule

### tb/quadrature_detent_accelerator_top_test.sv
// ----------------------------------------------------------------------------
// quadrature_detent_accelerator_top_test
// Drives encoder sample words into the quadrature detent accelerator: a short
// directed turn, then random turns with glitches under several register
// settings, with random stalls on both channels. The scoreboard checks every
// result word; this module only makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module quadrature_detent_accelerator_top_test;
    import qda_pkg::*;

    localparam int LATENCY     = 2;
    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 120;

    logic              clk;
    logic              rst_n;
    int                failures;
    int                outstanding;

    logic [1:0]        enc_pos;
    logic [TIME_W-1:0] clock_ms;
    bit                tx_quiet = 1'b0;
    bit                rx_quiet = 1'b0;

    qda_sample_if sample_ch ();
    qda_result_if result_ch ();
    qda_cfg_if    cfg_ch ();

    quadrature_detent_accelerator_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    qda_detent_scoreboard scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample_ch),
        .result      (result_ch),
        .cfg         (cfg_ch),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[quadrature_detent_accelerator_top] ERROR");
        $finish;
    end

    // Result side: random gaps per word, quiet stretches, two long hold-offs
    initial
    begin : receiver
        int   gap;
        int   hold;
        int   taken;
        logic ready_next;
        gap = 0;
        hold = 0;
        taken = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (result_ch.valid && result_ch.ready)
                begin
                    taken++;
                    if (taken == 150 || taken == 800)
                        hold = LONG_HOLD;
                    if ($urandom_range(0, 39) == 0)
                        rx_quiet = !rx_quiet;
                    gap = rx_quiet ? 0 : $urandom_range(0, 5);
                end
                if (hold > 0)
                begin
                    hold--;
                    ready_next = 1'b0;
                end
                else if (gap > 0)
                begin
                    gap--;
                    ready_next = 1'b0;
                end
                else
                    ready_next = 1'b1;
                result_ch.ready <= ready_next;
            end
        end
    end

    // Forward order of line pairs: 00, 10, 11, 01
    function automatic logic [1:0] pos_lines(logic [1:0] p);
        return {p[1] ^ p[0], p[1]};
    endfunction

    task automatic send_sample(logic [1:0] lines, logic [TIME_W-1:0] now);
        int gap;
        if ($urandom_range(0, 49) == 0)
            tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.line_a <= lines[1];
        sample_ch.line_b <= lines[0];
        sample_ch.now_ms <= now;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    task automatic turn(int dir, int dt);
        enc_pos = enc_pos + 2'(dir);
        clock_ms = clock_ms + TIME_W'(dt);
        send_sample(pos_lines(enc_pos), clock_ms);
    endtask

    // Drop valid, drain every expected word, then let the pipeline settle
    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Upper data bits beyond each register's width carry junk on purpose
    task automatic configure(logic [TIMEOUT_W-1:0] timeout, logic [THRESH_W-1:0] thresh,
                             logic [MULT_W-1:0] mult);
        write_reg(REG_ACCEL_TIMEOUT, timeout);
        write_reg(REG_ACCEL_THRESHOLD, {8'($urandom()), thresh});
        write_reg(REG_ACCEL_MULTIPLIER, {11'($urandom()), mult});
    endtask

    // Runs of clean edges in one direction, with occasional glitch samples
    task automatic spin(int items, int max_dt, int reverse_pct, int noise_pct,
                        bit time_jumps);
        int sent;
        int dir;
        sent = 0;
        dir = 1;
        while (sent < items)
        begin
            if ($urandom_range(0, 99) < noise_pct)
            begin
                case ($urandom_range(0, 2))
                    0: if (time_jumps) clock_ms = $urandom();
                    1: enc_pos = 2'($urandom());
                    default: clock_ms = clock_ms + $urandom_range(0, 3);
                endcase
                send_sample(pos_lines(enc_pos), clock_ms);
                sent++;
            end
            else
            begin
                if ($urandom_range(0, 99) < reverse_pct)
                    dir = -dir;
                repeat ($urandom_range(1, 12))
                begin
                    turn(dir, $urandom_range(0, max_dt));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin : stimulus
        rst_n            <= 1'b0;
        sample_ch.valid  <= 1'b0;
        sample_ch.line_a <= 1'b0;
        sample_ch.line_b <= 1'b0;
        sample_ch.now_ms <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= REG_ACCEL_TIMEOUT;
        cfg_ch.data      <= '0;
        enc_pos  = 2'd2;
        clock_ms = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Priming sample, then the first of three fast detents that switch acceleration on
        send_sample(pos_lines(enc_pos), clock_ms);
        repeat (4) turn(1, 10);
        // Both lines flip at once, then the same pair again
        enc_pos  = enc_pos + 2'd2;
        clock_ms = 45;
        send_sample(pos_lines(enc_pos), clock_ms);
        clock_ms = 46;
        send_sample(pos_lines(enc_pos), clock_ms);
        repeat (8) turn(1, 10);
        // Slow detent backwards clears acceleration
        repeat (3) turn(-1, 10);
        turn(-1, 900);
        // Detent across the timestamp wrap
        clock_ms = '1 - 3;
        repeat (4) turn(-1, 1);

        configure(16'hFFFF, 8'd0, 5'd31);
        spin(70, 40, 30, 10, 1'b1);
        configure(16'd0, 8'd255, 5'd0);
        spin(70, 40, 30, 10, 1'b1);
        configure(16'd200, 8'd1, 5'd16);
        spin(70, 150, 20, 10, 1'b1);
        configure(16'd50, 8'd2, 5'd0);
        spin(70, 30, 20, 10, 1'b1);
        configure(16'($urandom_range(0, 300)), 8'($urandom_range(0, 6)), 5'($urandom()));
        spin(70, 80, 25, 10, 1'b1);

        // Long fast turn: drive the fast-detent count up to its ceiling
        configure(16'hFFFF, 8'd255, 5'd16);
        repeat (4)
        begin
            spin(300, 5, 2, 2, 1'b0);
            wait_idle();
        end

        wait_idle();
        if (failures == 0)
            $display("[quadrature_detent_accelerator_top] OK");
        else
            $display("[quadrature_detent_accelerator_top] ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/qda_pkg.sv
rtl/qda_ifs.sv
rtl/qda_cfg.sv
rtl/qda_core.sv
rtl/quadrature_detent_accelerator_top.sv
tb/qda_detent_scoreboard.sv
tb/quadrature_detent_accelerator_top_test.sv
